FILE: rtl/core/bbfl_pkg.sv
`default_nettype none

package bbfl_pkg;

  localparam int MAX_BLOCKS_DEF  = 32768;
  localparam int PROBE_COUNT_DEF = 8;

  localparam int WORDS_PER_BLOCK = 8;
  localparam int WORD_BITS       = 64;
  localparam int BLOCK_BITS      = 512;
  localparam int POS_W           = $clog2(BLOCK_BITS);
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int DIV_STEPS       = 32;
  localparam int CFG_W           = 16;

  localparam logic [63:0]      FNV_BASIS         = 64'hCBF2_9CE4_8422_2325;
  localparam logic [31:0]      PROBE_STEP        = 32'h5BD1_E995;
  localparam logic [CFG_W-1:0] RESET_BLOCK_COUNT = 16'd18750;

  localparam logic REG_BLOCK_COUNT   = 1'b0;
  localparam logic REG_FILTER_ENABLE = 1'b1;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_LOAD = 1'b1
  } command_t;

  typedef struct packed {
    command_t              command;
    logic [7:0]            char_byte;
    logic                  last_char;
    logic [17:0]           word_address;
    logic [WORD_BITS-1:0]  word_data;
  } in_word_t;

  typedef struct packed {
    logic        is_blocked;
    logic [14:0] block_index;
  } out_word_t;

  typedef struct packed {
    logic hash_en;
    logic load_en;
    logic start;
    logic div_step;
    logic probe_rd;
    logic probe_chk;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic probe_last;
    logic out_free;
  } ctrl_sts_t;

  // One FNV-1a round. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bbfl_ctrl.sv
`default_nettype none

module bbfl_ctrl
  import bbfl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire command_t  req_command,
  input  wire logic      req_last,
  output logic           req_stall,
  output ctrl_cmd_t      cmd,
  input  wire ctrl_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.hash_en = accept && (req_command == CMD_BYTE);
        cmd.load_en = accept && (req_command == CMD_LOAD);
        cmd.start   = cmd.hash_en && req_last;
        if (cmd.start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        cmd.probe_chk = 1'b1;
        state_next    = sts.probe_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_DIV)
    else $error("query start did not enter the divide phase");

  a_probe_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && sts.probe_last) |=> state == S_DONE)
    else $error("last probe check did not finish the query");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.hash_en, cmd.load_en, cmd.div_step, cmd.probe_rd,
              cmd.probe_chk, cmd.out_load}))
    else $error("more than one datapath command in one cycle");

endmodule

`default_nettype wire

FILE: rtl/core/bbfl_datapath.sv
`default_nettype none

module bbfl_datapath
  import bbfl_pkg::*;
#(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int PROBE_COUNT = PROBE_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_word_t         req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output out_word_t             rsp,
  input  wire ctrl_cmd_t        cmd,
  output ctrl_sts_t             sts
);

  localparam int STORE_WORDS = MAX_BLOCKS * WORDS_PER_BLOCK;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PW          = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  logic [CFG_W-1:0]     block_count;
  logic                 filter_enable;
  logic [63:0]          hash;
  logic [63:0]          h_next;
  logic [31:0]          dividend;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     rem_next;
  logic [CNT_W-1:0]     divisor;
  logic [CNT_W-1:0]     active_n;
  logic [CNT_W:0]       trial;
  logic [DIV_CW-1:0]    div_cnt;
  logic [POS_W-1:0]     hlow;
  logic [POS_W-1:0]     mix;
  logic [POS_W-1:0]     pos;
  logic [PW-1:0]        pcnt;
  logic [BIT_W-1:0]     bit_sel;
  logic                 hit;
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_ok;

  logic [WORD_BITS-1:0] mem [0:STORE_WORDS-1];

  assign h_next = fnv_step(hash, req.char_byte);

  always_comb begin
    if (block_count == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(block_count) > 32'(MAX_BLOCKS)) begin
      active_n = CNT_W'(MAX_BLOCKS);
    end else begin
      active_n = CNT_W'(block_count);
    end
  end

  // Restoring division of the upper hash half, one quotient bit per step.
  assign trial    = {rem, dividend[31]};
  assign rem_next = (trial >= {1'b0, divisor}) ? CNT_W'(trial - {1'b0, divisor})
                                               : CNT_W'(trial);

  assign pos     = hlow ^ mix;
  assign rd_addr = AW'({rem[BLK_W-1:0], pos[POS_W-1:BIT_W]});
  assign wr_addr = AW'(req.word_address);
  assign wr_ok   = 32'(req.word_address) < 32'(STORE_WORDS);

  assign sts.div_last   = (div_cnt == DIV_CW'(DIV_STEPS - 1));
  assign sts.probe_last = (pcnt == PW'(PROBE_COUNT - 1));
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= RESET_BLOCK_COUNT;
      filter_enable <= 1'b0;
      hash          <= FNV_BASIS;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BLOCK_COUNT:   block_count   <= cfg_data;
          REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        endcase
      end
      if (cmd.start) begin
        hash <= FNV_BASIS;
      end else if (cmd.hash_en) begin
        hash <= h_next;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend <= h_next[63:32];
      hlow     <= h_next[POS_W-1:0];
      rem      <= '0;
      divisor  <= active_n;
      div_cnt  <= '0;
      mix      <= '0;
      pcnt     <= '0;
      hit      <= 1'b1;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[30:0], 1'b0};
      rem      <= rem_next;
      div_cnt  <= div_cnt + DIV_CW'(1);
    end
    if (cmd.probe_rd) begin
      bit_sel <= pos[BIT_W-1:0];
    end
    if (cmd.probe_chk) begin
      hit  <= hit & rd_data[bit_sel];
      pcnt <= pcnt + PW'(1);
      mix  <= mix + PROBE_STEP[POS_W-1:0];
    end
    if (cmd.out_load) begin
      rsp.is_blocked  <= hit & filter_enable;
      rsp.block_index <= 15'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && wr_ok) begin
      mem[wr_addr] <= req.word_data;
    end
    if (cmd.probe_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp_valid)
    else $error("result load did not raise the output valid");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_rd |-> rem < divisor)
    else $error("selected block is not below the block count");

  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> hash == FNV_BASIS)
    else $error("hash did not restart after the final name byte");

endmodule

`default_nettype wire

FILE: rtl/core/blocked_bloom_filter_lookup_unit.sv
`default_nettype none

// Channel  | Direction | Handshake            | Word
// cfg      | in        | cfg_we               | cfg_index, cfg_data
// req      | in        | req_valid, req_stall | req (in_word_t)
// rsp      | out       | rsp_valid, rsp_stall | rsp (out_word_t)
//
// A load word or a name byte that is not the last is taken without raising req_stall.
// A final name byte starts a query: the one-bit-a-cycle divider picks a block, then each probe
// reads and checks a store word on the single read port; the result loads once the output is free.
// Reset restores the hash, block count and enable; the filter store is not cleared.
// req_stall is high while a query finishes; a waiting result sits in the output register.

module blocked_bloom_filter_lookup_unit
  import bbfl_pkg::*;
#(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int PROBE_COUNT = PROBE_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire in_word_t         req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output out_word_t             rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bbfl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_last    (req.last_char),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  bbfl_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .PROBE_COUNT (PROBE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
